// ----- hw/rtl/u2c_pkg.sv -----
// Shared types, constants and decode/map functions for the UTF-8 to CP1251 transcoder.
// No dependencies; imported by every module of the block.
package u2c_pkg;

  localparam logic [7:0] QMARK = 8'h3F;
  localparam int unsigned CP_W = 21;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
  } out_rsp_t;

  // One decided sequence waiting for the back end
  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            run_last;
    logic            string_end;
  } q_entry_t;

  // Outcome of looking at the head of the byte buffer
  typedef struct packed {
    logic            emit;
    logic [2:0]      len;
    logic [CP_W-1:0] cp;
  } dec_t;

  function automatic logic [2:0] seq_len(input logic [7:0] c0);
    logic [2:0] l;
    l = 3'd0;
    if (c0[7:5] == 3'b110) l = 3'd2;
    else if (c0[7:4] == 4'b1110) l = 3'd3;
    else if (c0[7:3] == 5'b11110) l = 3'd4;
    return l;
  endfunction

  // Decide the sequence at the head of buf (byte 0 first), avail bytes present.
  function automatic dec_t classify(input logic [3:0][7:0] buf_in, input logic [2:0] avail,
                                    input logic last);
    dec_t       d;
    logic [2:0] l;
    logic [2:0] chk;
    logic       bad;
    d.emit = 1'b0;
    d.len  = 3'd0;
    d.cp   = '0;
    l      = seq_len(buf_in[0]);
    chk    = (avail < l) ? avail : l;
    bad    = 1'b0;
    for (int j = 1; j < 4; j++) begin
      if ((3'(j) < chk) && (buf_in[j][7:6] != 2'b10)) bad = 1'b1;
    end
    if (avail == 3'd0) begin
      d.emit = 1'b0;
    end else if (!buf_in[0][7]) begin
      d.emit = 1'b1;
      d.len  = 3'd1;
      d.cp   = CP_W'(buf_in[0]);
    end else if (l == 3'd0) begin
      d.emit = 1'b1;
      d.len  = 3'd1;
      d.cp   = CP_W'(QMARK);
    end else if (!bad && (avail >= l)) begin
      d.emit = 1'b1;
      d.len  = l;
      case (l)
        3'd2:    d.cp = {10'd0, buf_in[0][4:0], buf_in[1][5:0]};
        3'd3:    d.cp = {5'd0, buf_in[0][3:0], buf_in[1][5:0], buf_in[2][5:0]};
        default: d.cp = {buf_in[0][2:0], buf_in[1][5:0], buf_in[2][5:0], buf_in[3][5:0]};
      endcase
    end else if (bad || last) begin
      d.emit = 1'b1;
      d.len  = 3'd1;
      d.cp   = CP_W'(QMARK);
    end
    return d;
  endfunction

  function automatic logic [7:0] map_cp(input logic [CP_W-1:0] cp);
    logic [CP_W-1:0] diff;
    logic [7:0]      b;
    diff = cp - CP_W'(21'h410);
    b    = QMARK;
    if (cp <= CP_W'(21'h7F)) begin
      b = cp[7:0];
    end else if (cp inside {[21'h410:21'h44F]}) begin
      b = {2'b11, diff[5:0]};
    end else begin
      case (cp)
        21'h0402: b = 8'h80;  21'h0403: b = 8'h81;  21'h201A: b = 8'h82;
        21'h0453: b = 8'h83;  21'h201E: b = 8'h84;  21'h2026: b = 8'h85;
        21'h2020: b = 8'h86;  21'h2021: b = 8'h87;  21'h20AC: b = 8'h88;
        21'h2030: b = 8'h89;  21'h0409: b = 8'h8A;  21'h2039: b = 8'h8B;
        21'h040A: b = 8'h8C;  21'h040C: b = 8'h8D;  21'h040B: b = 8'h8E;
        21'h040F: b = 8'h8F;  21'h0452: b = 8'h90;  21'h2018: b = 8'h91;
        21'h2019: b = 8'h92;  21'h201C: b = 8'h93;  21'h201D: b = 8'h94;
        21'h2022: b = 8'h95;  21'h2013: b = 8'h96;  21'h2014: b = 8'h97;
        21'h2122: b = 8'h99;  21'h0459: b = 8'h9A;  21'h203A: b = 8'h9B;
        21'h045A: b = 8'h9C;  21'h045C: b = 8'h9D;  21'h045B: b = 8'h9E;
        21'h045F: b = 8'h9F;  21'h00A0: b = 8'hA0;  21'h040E: b = 8'hA1;
        21'h045E: b = 8'hA2;  21'h0408: b = 8'hA3;  21'h00A4: b = 8'hA4;
        21'h0490: b = 8'hA5;  21'h00A6: b = 8'hA6;  21'h00A7: b = 8'hA7;
        21'h0401: b = 8'hA8;  21'h00A9: b = 8'hA9;  21'h0404: b = 8'hAA;
        21'h00AB: b = 8'hAB;  21'h00AC: b = 8'hAC;  21'h00AD: b = 8'hAD;
        21'h00AE: b = 8'hAE;  21'h0407: b = 8'hAF;  21'h00B0: b = 8'hB0;
        21'h00B1: b = 8'hB1;  21'h0406: b = 8'hB2;  21'h0456: b = 8'hB3;
        21'h0491: b = 8'hB4;  21'h00B5: b = 8'hB5;  21'h00B6: b = 8'hB6;
        21'h00B7: b = 8'hB7;  21'h0451: b = 8'hB8;  21'h2116: b = 8'hB9;
        21'h0454: b = 8'hBA;  21'h00BB: b = 8'hBB;  21'h0458: b = 8'hBC;
        21'h0405: b = 8'hBD;  21'h0455: b = 8'hBE;  21'h0457: b = 8'hBF;
        default:  b = QMARK;
      endcase
    end
    return b;
  endfunction

endpackage

// ----- hw/rtl/u2c_front.sv -----
// Front end: takes input requests, holds the bytes of an unfinished sequence and
// decides one sequence per cycle into the queue while the queue has room. Depends on u2c_pkg.
module u2c_front import u2c_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_req,
  input  logic     q_full,
  output logic     q_push,
  output q_entry_t q_wdata
);

  logic [3:0][7:0] buf_r, buf_nxt;
  logic [2:0]      cnt_r, cnt_nxt;
  logic            last_r, last_nxt;
  logic            busy_r, busy_nxt;

  logic [3:0][7:0] work_buf, rest_buf;
  logic [2:0]      work_n, rest_n;
  logic            work_last, act, rest_done;
  dec_t            head, follow;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      last_r <= 1'b0;
      busy_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      last_r <= last_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

  always_comb begin
    in_stall  = busy_r | q_full;
    work_buf  = buf_r;
    work_n    = cnt_r;
    work_last = last_r;
    act       = 1'b0;
    if (busy_r) begin
      act = !q_full;
    end else if (in_valid && !q_full) begin
      // idle: at most three bytes held, append the new one
      act                    = 1'b1;
      work_buf[cnt_r[1:0]]   = in_req.data_byte;
      work_n                 = cnt_r + 3'd1;
      work_last              = in_req.last_byte;
    end

    head      = classify(work_buf, work_n, work_last);
    rest_buf  = work_buf >> {head.len, 3'b000};
    rest_n    = work_n - head.len;
    // look one sequence ahead to flag the last result of this request
    follow    = classify(rest_buf, rest_n, work_last);
    rest_done = !follow.emit;

    q_push             = act & head.emit;
    q_wdata.cp         = head.cp;
    q_wdata.run_last   = rest_done;
    q_wdata.string_end = rest_done & work_last;

    buf_nxt  = buf_r;
    cnt_nxt  = cnt_r;
    last_nxt = last_r;
    busy_nxt = busy_r;
    if (act) begin
      last_nxt = work_last;
      if (head.emit) begin
        buf_nxt  = rest_buf;
        cnt_nxt  = rest_n;
        busy_nxt = !rest_done;
      end else begin
        buf_nxt  = work_buf;
        cnt_nxt  = work_n;
        busy_nxt = 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/u2c_fifo.sv -----
// Small queue of decided sequences between front and back end.
// Depends on u2c_pkg for the entry type.
module u2c_fifo import u2c_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t wdata,
  output logic     full,
  input  logic     pop,
  output q_entry_t rdata,
  output logic     valid
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  q_entry_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_comb begin
    full       = (cnt_r == FULL_CNT);
    valid      = (cnt_r != '0);
    rdata      = mem_r[rd_ptr_r];
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) cnt_nxt = cnt_r + CNT_W'(1);
    else if (pop && !push) cnt_nxt = cnt_r - CNT_W'(1);
  end

endmodule

// ----- hw/rtl/u2c_back.sv -----
// Back end: maps queued code points to CP1251 bytes into the output register.
// Depends on u2c_pkg for map_cp and the channel types.
module u2c_back import u2c_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_valid,
  input  q_entry_t q_rdata,
  output logic     q_pop,
  output logic     out_valid,
  input  logic     out_stall,
  output out_rsp_t out_rsp
);

  logic     valid_r, valid_nxt;
  out_rsp_t rsp_r, rsp_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rsp_r <= rsp_nxt;
  end

  always_comb begin
    q_pop     = q_valid && (!valid_r || !out_stall);
    valid_nxt = valid_r && out_stall;
    rsp_nxt   = rsp_r;
    if (q_pop) begin
      valid_nxt          = 1'b1;
      rsp_nxt.out_byte   = map_cp(q_rdata.cp);
      rsp_nxt.run_last   = q_rdata.run_last;
      rsp_nxt.string_end = q_rdata.string_end;
    end
  end

  assign out_valid = valid_r;
  assign out_rsp   = rsp_r;

endmodule

// ----- hw/rtl/utf8_to_cp1251_transcoder_core.sv -----
// UTF-8 to Windows-1251 transcoder. A result is pushed into the queue by the request that
// completes its sequence and then registered in the output register. Throughput: one input
// byte per cycle while each byte gives at most one result and the queue has room; a request
// that decides several sequences holds the input while the front end decides them in turn.
// Synchronous active-low reset empties the pending buffer, the queue and the output register.
module utf8_to_cp1251_transcoder_core import u2c_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output out_rsp_t out_rsp
);

  logic     q_push, q_full, q_pop, q_valid;
  q_entry_t q_wdata, q_rdata;

  u2c_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  u2c_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .valid (q_valid)
  );

  u2c_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue push while full");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.string_end) |-> out_rsp.run_last)
    else $error("string end without run last");

  a_back_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && !out_valid) |=> out_valid)
    else $error("queued entry not moved to output");

endmodule
